// File: rtl/core/dpd_pkg.sv
package dpd_pkg;

  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChEnd   = 8'h23;
  localparam logic [7:0] ChAck   = 8'h2B;
  localparam logic [7:0] ChNak   = 8'h2D;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_RETX = 2'd3
  } kind_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/core/dpd_stream_if.sv
interface dpd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface dpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output result_kind, output data_byte, output last,
                  input ready);
  modport sink   (input valid, input result_kind, input data_byte, input last,
                  output ready);
endinterface

// File: rtl/core/debug_packet_deframer_core.sv
// Channel | Dir | Payload                          | Handshake
// in_i    | in  | action, rx_byte                  | valid/ready
// out_o   | out | result_kind, data_byte, last     | valid/ready
//
// One request per cycle while ready is high; framing and checksum resolve in
// the accepting cycle. A request yields 0..2 results, queued in a 4-entry
// result buffer. Input ready while at least two buffer slots are free; a nak
// while an ack is awaited adds a retransmit to the framed result.
// Async active-low reset: idle phase, sum and ack flag cleared, buffer empty.
module debug_packet_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpd_in_if.sink     in_i,
  dpd_out_if.source  out_o
);

  dpd_pkg::phase_e  phase_q, phase_d;
  logic [7:0]       sum_q, sum_d;
  logic [3:0]       hi_q, hi_d;
  logic             hi_ok_q, hi_ok_d;
  logic             ack_q, ack_d;

  dpd_pkg::result_t                 buf_q [dpd_pkg::ResDepth];
  logic [dpd_pkg::ResPtrW-1:0]      wptr_q, rptr_q;
  logic [dpd_pkg::ResCntW-1:0]      cnt_q;

  logic             acc, pop;
  logic             skip, retx, frm_res;
  dpd_pkg::kind_e   frm_kind;
  logic [7:0]       frm_data;
  dpd_pkg::hex_t    hx;
  dpd_pkg::result_t e0, e1;
  logic [1:0]       n_res;
  logic [7:0]       c;

  assign c         = in_i.rx_byte;
  assign in_i.ready = (cnt_q <= dpd_pkg::ResCntW'(dpd_pkg::ResDepth - 2));
  assign acc       = in_i.valid && in_i.ready;
  assign pop       = out_o.valid && out_o.ready;
  assign hx        = dpd_pkg::hex_value(c);

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    hi_d     = hi_q;
    hi_ok_d  = hi_ok_q;
    ack_d    = ack_q;
    skip     = 1'b0;
    retx     = 1'b0;
    frm_res  = 1'b0;
    frm_kind = dpd_pkg::KIND_DATA;
    frm_data = 8'd0;
    if (in_i.action) begin
      ack_d = 1'b1;
      skip  = 1'b1;
    end else if (ack_q) begin
      if (c == dpd_pkg::ChAck || c == dpd_pkg::ChStart) begin
        ack_d = 1'b0;
      end else if (c == dpd_pkg::ChNak) begin
        retx = 1'b1;
      end else begin
        skip = 1'b1;
      end
    end
    if (!skip) begin
      case (phase_q)
        dpd_pkg::PH_IDLE: begin
          if (c == dpd_pkg::ChStart) begin
            phase_d = dpd_pkg::PH_DATA;
            sum_d   = 8'd0;
            hi_d    = 4'd0;
            hi_ok_d = 1'b0;
          end
        end
        dpd_pkg::PH_DATA: begin
          if (c == dpd_pkg::ChEnd) begin
            phase_d = dpd_pkg::PH_DIG1;
          end else begin
            sum_d    = sum_q + c;
            frm_res  = 1'b1;
            frm_data = c;
          end
        end
        dpd_pkg::PH_DIG1: begin
          hi_ok_d = hx.ok;
          hi_d    = hx.val;
          phase_d = dpd_pkg::PH_DIG2;
        end
        default: begin
          frm_res  = 1'b1;
          frm_kind = (hi_ok_q && hx.ok && {hi_q, hx.val} == sum_q) ?
                     dpd_pkg::KIND_GOOD : dpd_pkg::KIND_BAD;
          phase_d  = dpd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    e1.kind = frm_kind;
    e1.data = frm_data;
    e1.last = 1'b1;
    if (retx) begin
      e0.kind = dpd_pkg::KIND_RETX;
      e0.data = 8'd0;
      e0.last = !frm_res;
    end else begin
      e0 = e1;
    end
    n_res = {1'b0, retx} + {1'b0, frm_res};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dpd_pkg::PH_IDLE;
      sum_q   <= 8'd0;
      hi_q    <= 4'd0;
      hi_ok_q <= 1'b0;
      ack_q   <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      hi_q    <= hi_d;
      hi_ok_q <= hi_ok_d;
      ack_q   <= ack_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && n_res != 2'd0) begin
      buf_q[wptr_q] <= e0;
    end
    if (acc && n_res == 2'd2) begin
      buf_q[wptr_q + dpd_pkg::ResPtrW'(1)] <= e1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (acc) begin
        wptr_q <= wptr_q + dpd_pkg::ResPtrW'(n_res);
      end
      if (pop) begin
        rptr_q <= rptr_q + dpd_pkg::ResPtrW'(1);
      end
      cnt_q <= cnt_q + (acc ? dpd_pkg::ResCntW'(n_res) : '0)
                     - dpd_pkg::ResCntW'(pop);
    end
  end

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.result_kind = buf_q[rptr_q].kind;
  assign out_o.data_byte   = buf_q[rptr_q].data;
  assign out_o.last        = buf_q[rptr_q].last;

endmodule
